FILE: hw/rtl/pac_pkg.sv
// Package for the patch column address generator.
// Holds field widths, limits, register indexes and the structs passed between modules.
// No dependencies.
package pac_pkg;

  localparam int MAX_DIM   = 1024;
  localparam int MAX_BLOCK = 32;

  localparam int DIM_W    = 11;  // image size and stride registers
  localparam int BLK_W    = 6;   // block size registers
  localparam int POS_W    = 10;  // patch origin and the src_row, src_col and dst_row fields
  localparam int INNER_W  = 5;   // in-patch offsets
  localparam int PCOUNT_W = 20;  // patch index
  localparam int CIDX_W   = 3;   // configuration register index

  typedef enum logic [CIDX_W-1:0] {
    REG_IMAGE_ROWS = 3'd0,
    REG_IMAGE_COLS = 3'd1,
    REG_BLOCK_ROWS = 3'd2,
    REG_BLOCK_COLS = 3'd3,
    REG_ROW_STRIDE = 3'd4,
    REG_COL_STRIDE = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0] image_rows;
    logic [DIM_W-1:0] image_cols;
    logic [BLK_W-1:0] block_rows;
    logic [BLK_W-1:0] block_cols;
    logic [DIM_W-1:0] row_stride;
    logic [DIM_W-1:0] col_stride;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0]    src_row;
    logic [POS_W-1:0]    src_col;
    logic [POS_W-1:0]    dst_row;
    logic [PCOUNT_W-1:0] dst_col;
    logic                patch_end;
    logic                last;
    logic                bad_config;
  } result_t;

endpackage

FILE: hw/rtl/pac_in_if.sv
// Input channel of the patch column address generator: valid, ready, restart.
// Does not import pac_pkg or depend on any other file.
interface pac_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

FILE: hw/rtl/pac_out_if.sv
// Result channel of the patch column address generator: valid, ready, one copy pair and its flags.
// Depends on pac_pkg for the field widths.
interface pac_out_if
  import pac_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [POS_W-1:0]    src_row;
  logic [POS_W-1:0]    src_col;
  logic [POS_W-1:0]    dst_row;
  logic [PCOUNT_W-1:0] dst_col;
  logic                patch_end;
  logic                last;
  logic                bad_config;

  modport source (output valid, output src_row, output src_col, output dst_row,
                  output dst_col, output patch_end, output last, output bad_config,
                  input ready);
  modport sink   (input valid, input src_row, input src_col, input dst_row,
                  input dst_col, input patch_end, input last, input bad_config,
                  output ready);
endinterface

FILE: hw/rtl/pac_cfg.sv
// Configuration register bank of the patch column address generator.
// Depends on pac_pkg for cfg_t and the register indexes.
module pac_cfg
  import pac_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_idx,
  input  logic [DIM_W-1:0]  cfg_wdata,
  output cfg_t              cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        REG_IMAGE_ROWS: cfg_nxt.image_rows = cfg_wdata;
        REG_IMAGE_COLS: cfg_nxt.image_cols = cfg_wdata;
        REG_BLOCK_ROWS: cfg_nxt.block_rows = cfg_wdata[BLK_W-1:0];
        REG_BLOCK_COLS: cfg_nxt.block_cols = cfg_wdata[BLK_W-1:0];
        REG_ROW_STRIDE: cfg_nxt.row_stride = cfg_wdata;
        REG_COL_STRIDE: cfg_nxt.col_stride = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_rows <= DIM_W'(MAX_DIM);
      cfg_r.image_cols <= DIM_W'(MAX_DIM);
      cfg_r.block_rows <= BLK_W'(3);
      cfg_r.block_cols <= BLK_W'(3);
      cfg_r.row_stride <= DIM_W'(1);
      cfg_r.col_stride <= DIM_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hw/rtl/pac_walk.sv
// Walk state and address arithmetic of the patch column address generator.
// Produces the copy pair for the current element and steps the walk on each transfer.
// Depends on pac_pkg.
module pac_walk
  import pac_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    step,
  input  logic    restart,
  output result_t res
);

  logic [POS_W-1:0]    top_r, top_nxt, left_r, left_nxt;
  logic [INNER_W-1:0]  irow_r, irow_nxt, icol_r, icol_nxt;
  logic [PCOUNT_W-1:0] pcnt_r, pcnt_nxt;

  // state as seen after an optional restart
  logic [POS_W-1:0]    top, left;
  logic [INNER_W-1:0]  irow, icol;
  logic [PCOUNT_W-1:0] pcnt;

  logic [DIM_W-1:0]   sr, sc;
  logic               bad, row_final, col_final, row_more, col_more, pend, fin;
  logic [BLK_W-1:0]   irow_inc, icol_inc;
  logic [DIM_W+1:0]   nt, nl, nt_end, nl_end;
  logic [DIM_W-1:0]   clamp_top, clamp_left;
  logic [DIM_W-1:0]   prod;
  logic [DIM_W:0]     dst_sum;
  logic [DIM_W-1:0]   srow_sum, scol_sum;

  always_comb begin
    top  = restart ? '0 : top_r;
    left = restart ? '0 : left_r;
    irow = restart ? '0 : irow_r;
    icol = restart ? '0 : icol_r;
    pcnt = restart ? '0 : pcnt_r;

    sr = (cfg.row_stride == '0) ? DIM_W'(1) : cfg.row_stride;
    sc = (cfg.col_stride == '0) ? DIM_W'(1) : cfg.col_stride;

    bad = (cfg.block_rows == '0) || (cfg.block_cols == '0) ||
          (cfg.block_rows > BLK_W'(MAX_BLOCK)) || (cfg.block_cols > BLK_W'(MAX_BLOCK)) ||
          (cfg.image_rows == '0) || (cfg.image_cols == '0) ||
          (cfg.image_rows > DIM_W'(MAX_DIM)) || (cfg.image_cols > DIM_W'(MAX_DIM)) ||
          (DIM_W'(cfg.block_rows) > cfg.image_rows) ||
          (DIM_W'(cfg.block_cols) > cfg.image_cols);

    row_final = (DIM_W'(top) + DIM_W'(cfg.block_rows)) >= cfg.image_rows;
    col_final = (DIM_W'(left) + DIM_W'(cfg.block_cols)) >= cfg.image_cols;
    irow_inc  = BLK_W'(irow) + BLK_W'(1);
    icol_inc  = BLK_W'(icol) + BLK_W'(1);
    row_more  = irow_inc < cfg.block_rows;
    col_more  = icol_inc < cfg.block_cols;
    pend      = !row_more && !col_more;
    fin       = pend && row_final && col_final;

    nt         = (DIM_W+2)'(top) + (DIM_W+2)'(sr);
    nl         = (DIM_W+2)'(left) + (DIM_W+2)'(sc);
    nt_end     = nt + (DIM_W+2)'(cfg.block_rows);
    nl_end     = nl + (DIM_W+2)'(cfg.block_cols);
    clamp_top  = cfg.image_rows - DIM_W'(cfg.block_rows);
    clamp_left = cfg.image_cols - DIM_W'(cfg.block_cols);

    prod     = DIM_W'(icol) * DIM_W'(cfg.block_rows);
    dst_sum  = (DIM_W+1)'(prod) + (DIM_W+1)'(irow);
    srow_sum = DIM_W'(top) + DIM_W'(irow);
    scol_sum = DIM_W'(left) + DIM_W'(icol);

    if (bad) begin
      res = '0;
      res.bad_config = 1'b1;
    end else begin
      res.src_row    = srow_sum[POS_W-1:0];
      res.src_col    = scol_sum[POS_W-1:0];
      res.dst_row    = dst_sum[POS_W-1:0];
      res.dst_col    = pcnt;
      res.patch_end  = pend;
      res.last       = fin;
      res.bad_config = 1'b0;
    end

    top_nxt  = top;
    left_nxt = left;
    irow_nxt = irow;
    icol_nxt = icol;
    pcnt_nxt = pcnt;
    if (!bad) begin
      if (!pend) begin
        if (row_more) begin
          irow_nxt = irow_inc[INNER_W-1:0];
        end else begin
          irow_nxt = '0;
          icol_nxt = icol_inc[INNER_W-1:0];
        end
      end else if (fin) begin
        top_nxt  = '0;
        left_nxt = '0;
        irow_nxt = '0;
        icol_nxt = '0;
        pcnt_nxt = '0;
      end else begin
        irow_nxt = '0;
        icol_nxt = '0;
        pcnt_nxt = pcnt + PCOUNT_W'(1);
        if (row_final) begin
          // bottom band done: next patch column, back to the top
          left_nxt = (nl_end >= (DIM_W+2)'(cfg.image_cols)) ? clamp_left[POS_W-1:0]
                                                             : nl[POS_W-1:0];
          top_nxt  = '0;
        end else begin
          top_nxt  = (nt_end >= (DIM_W+2)'(cfg.image_rows)) ? clamp_top[POS_W-1:0]
                                                             : nt[POS_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r  <= '0;
      left_r <= '0;
      irow_r <= '0;
      icol_r <= '0;
      pcnt_r <= '0;
    end else if (step) begin
      top_r  <= top_nxt;
      left_r <= left_nxt;
      irow_r <= irow_nxt;
      icol_r <= icol_nxt;
      pcnt_r <= pcnt_nxt;
    end
  end

endmodule

FILE: hw/rtl/pac_out_reg.sv
// Result register of the patch column address generator.
// Holds one copy pair until the receiver takes it; reloads in the same cycle it drains.
// Depends on pac_pkg for result_t.
module pac_out_reg
  import pac_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t load_data,
  input  logic    out_ready,
  output logic    out_valid,
  output result_t out_data,
  output logic    can_load
);

  logic    valid_r, valid_nxt;
  result_t data_r;

  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

FILE: hw/rtl/patch_column_address_generator.sv
// Patch column address generator: im2col copy pair generator, one pair per input transfer.
// Depends on pac_pkg, pac_in_if, pac_out_if, pac_cfg, pac_walk and pac_out_reg.
//
// Use:
//   in_ch  : valid/ready channel carrying restart. restart=1 moves the walk to its
//            first element before issuing; restart=0 issues the current element.
//   out_ch : valid/ready channel with src_row/src_col, dst_row/dst_col, patch_end,
//            last and bad_config. Fields other than bad_config read zero while the
//            configuration is unusable, and the walk then holds still.
//   cfg_*  : write-only register port; cfg_idx selects image_rows, image_cols,
//            block_rows, block_cols, row_stride, col_stride (0..5). Write only while
//            no result is outstanding.
// Output: a result is registered and is valid in the cycle after its input transfer.
// Throughput: one pair per cycle while out_ch.ready is high; the walk step and addresses are
// computed combinationally from the walk registers, and the result register is reloaded in
// the cycle it drains.
// Stall: while the result register is full and out_ch.ready is low, in_ch.ready is
// low and the walk holds.
// Reset (rst_n low, synchronous): walk at its origin, result register empty,
// registers at 1024x1024 image, 3x3 block, unit strides.
module patch_column_address_generator
  import pac_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  pac_in_if.sink            in_ch,
  pac_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_idx,
  input  logic [DIM_W-1:0]  cfg_wdata
);

  cfg_t    cfg;
  result_t walk_res, out_res;
  logic    can_load, in_xfer, out_valid;

  pac_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign in_ch.ready = can_load;
  assign in_xfer     = in_ch.valid && can_load;

  pac_walk u_walk (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .step    (in_xfer),
    .restart (in_ch.restart),
    .res     (walk_res)
  );

  pac_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_xfer),
    .load_data (walk_res),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .out_data  (out_res),
    .can_load  (can_load)
  );

  assign out_ch.valid      = out_valid;
  assign out_ch.src_row    = out_res.src_row;
  assign out_ch.src_col    = out_res.src_col;
  assign out_ch.dst_row    = out_res.dst_row;
  assign out_ch.dst_col    = out_res.dst_col;
  assign out_ch.patch_end  = out_res.patch_end;
  assign out_ch.last       = out_res.last;
  assign out_ch.bad_config = out_res.bad_config;

  // a stalled result must block the input side
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while result stalled");

  a_last_ends_patch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.last) |-> out_ch.patch_end)
    else $error("last without patch_end");

  a_bad_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.bad_config) |->
      (out_ch.src_row == '0 && out_ch.src_col == '0 && out_ch.dst_row == '0 &&
       out_ch.dst_col == '0 && !out_ch.patch_end && !out_ch.last))
    else $error("bad_config result with non-zero fields");

  // a restart transfer issues the first element of the walk
  a_restart_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.restart) |=>
      (out_ch.valid && (out_ch.bad_config ||
       (out_ch.dst_col == '0 && out_ch.dst_row == '0 &&
        out_ch.src_row == '0 && out_ch.src_col == '0))))
    else $error("restart did not issue the walk origin");

endmodule
